// ===== rtl/core/bqc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqc_pkg
// Shared constants, command types and controller states for the biquad
// cascade filter.
// ----------------------------------------------------------------------------
package bqc_pkg;

	localparam int DEF_SECTIONS     = 3;
	localparam int DEF_SAMPLE_WIDTH = 16;
	localparam int DEF_COEF_WIDTH   = 18;

	// extra fractional bits carried in the delay words
	localparam int GUARD_BITS  = 8;
	localparam int WORD_W      = 32;
	localparam int REG_COUNT   = 6;
	localparam int CFG_INDEX_W = 3;

	// steps of one section
	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_FB_A1  = 3'd0;
	localparam logic [STEP_W-1:0] STEP_FB_A2  = 3'd1;
	localparam logic [STEP_W-1:0] STEP_FF_B1  = 3'd2;
	localparam logic [STEP_W-1:0] STEP_FF_B2  = 3'd3;
	localparam logic [STEP_W-1:0] STEP_FF_B0  = 3'd4;
	localparam logic [STEP_W-1:0] STEP_DRAIN  = 3'd5;
	localparam logic [STEP_W-1:0] STEP_FINISH = 3'd6;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		MUL_A1W1,
		MUL_A2W2,
		MUL_B1W1,
		MUL_B2W2,
		MUL_B0W
	} mul_sel_t;

	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_LOAD_X,
		ACC_SUB,
		ACC_LOAD_P,
		ACC_ADD
	} acc_op_t;

	typedef struct packed {
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     load_x;
		logic     latch_w;
		logic     finish;
		logic     load_out;
	} cmd_t;

endpackage

// ===== rtl/core/bqc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqc_ctrl
// Sequencer: walks each section through seven steps that share one
// multiplier and one accumulator, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module bqc_ctrl #(
	parameter int SECTIONS = 3,
	parameter int SEC_W    = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output bqc_pkg::cmd_t    cmd,
	output logic [SEC_W-1:0] sec
);
	import bqc_pkg::*;

	localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(SECTIONS - 1);

	state_t             state_q;
	state_t             state_d;
	logic [STEP_W-1:0]  step_q;
	logic [SEC_W-1:0]   sec_q;
	logic               out_valid_q;

	assign sec      = sec_q;
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_FB_A1;
			sec_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_x) begin
				step_q <= STEP_FB_A1;
				sec_q  <= '0;
			end else if (state_q == ST_RUN) begin
				if (step_q == STEP_FINISH) begin
					step_q <= STEP_FB_A1;
					if (sec_q != SEC_LAST) begin
						sec_q <= sec_q + SEC_W'(1);
					end
				end else begin
					step_q <= step_q + STEP_W'(1);
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		cmd.mul_sel  = MUL_B0W;
		cmd.acc_op   = ACC_HOLD;
		cmd.load_x   = 1'b0;
		cmd.latch_w  = 1'b0;
		cmd.finish   = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_x = 1'b1;
					state_d    = ST_RUN;
				end
			end
			ST_RUN: begin
				case (step_q)
					STEP_FB_A1: begin
						cmd.mul_sel = MUL_A1W1;
						cmd.acc_op  = ACC_LOAD_X;
					end
					STEP_FB_A2: begin
						cmd.mul_sel = MUL_A2W2;
						cmd.acc_op  = ACC_SUB;
					end
					STEP_FF_B1: begin
						cmd.mul_sel = MUL_B1W1;
						cmd.acc_op  = ACC_SUB;
					end
					// feedback sum is complete: take w, start the feedforward sum
					STEP_FF_B2: begin
						cmd.mul_sel = MUL_B2W2;
						cmd.acc_op  = ACC_LOAD_P;
						cmd.latch_w = 1'b1;
					end
					STEP_FF_B0: begin
						cmd.mul_sel = MUL_B0W;
						cmd.acc_op  = ACC_ADD;
					end
					STEP_DRAIN: begin
						cmd.acc_op = ACC_ADD;
					end
					STEP_FINISH: begin
						cmd.finish = 1'b1;
						if (sec_q == SEC_LAST) begin
							state_d = ST_DONE;
						end
					end
					default: begin
						cmd.acc_op = ACC_HOLD;
					end
				endcase
			end
			ST_DONE: begin
				// wait for the output register to be free
				if (!out_valid_q || m_tready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=>
		(state_q == ST_RUN && step_q == STEP_FB_A1 && sec_q == '0))
		else $error("item accepted but sequence did not start at first section");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (sec_q == SEC_LAST))
		else $error("result stage reached before last section");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || m_tready))
		else $error("output register overwritten while held");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> (out_valid_q && state_q == ST_IDLE))
		else $error("loaded result not presented");
`endif

endmodule

// ===== rtl/core/bqc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqc_datapath
// Coefficient registers, delay words, shared multiplier, accumulator and the
// round and saturate logic for the delay word and the section output.
// ----------------------------------------------------------------------------
module bqc_datapath #(
	parameter int SECTIONS     = 3,
	parameter int SAMPLE_WIDTH = 16,
	parameter int COEF_WIDTH   = 18,
	parameter int SEC_W        = 2
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bqc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [3*COEF_WIDTH-1:0]          cfg_data,
	input  bqc_pkg::cmd_t                    cmd,
	input  logic [SEC_W-1:0]                 sec,
	input  logic [SAMPLE_WIDTH-1:0]          in_sample,
	output logic [SAMPLE_WIDTH-1:0]          sample_out,
	output logic                             clipped
);
	import bqc_pkg::*;

	localparam int CF     = COEF_WIDTH - 2;
	localparam int PROD_W = COEF_WIDTH + WORD_W;
	localparam int ACC_W  = COEF_WIDTH + WORD_W + 3;
	localparam int XSHIFT = GUARD_BITS + CF;
	localparam int WR_W   = ACC_W - CF;
	localparam int YR_W   = ACC_W - CF - GUARD_BITS;

	localparam logic [3*COEF_WIDTH-1:0] FF_RESET = (3*COEF_WIDTH)'(1) << CF;
	localparam logic signed [ACC_W-1:0] W_HALF = ACC_W'(1) << (CF - 1);
	localparam logic signed [ACC_W-1:0] Y_HALF = ACC_W'(1) << (CF + GUARD_BITS - 1);
	localparam logic signed [WORD_W-1:0] W_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic signed [WORD_W-1:0] W_MIN = {1'b1, {(WORD_W-1){1'b0}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	logic [3*COEF_WIDTH-1:0]          coef_ff_q [SECTIONS];
	logic [2*COEF_WIDTH-1:0]          coef_fb_q [SECTIONS];
	logic signed [WORD_W-1:0]         w1_q [SECTIONS];
	logic signed [WORD_W-1:0]         w2_q [SECTIONS];

	logic signed [SAMPLE_WIDTH-1:0]   x_q;
	logic signed [WORD_W-1:0]         w_q;
	logic signed [PROD_W-1:0]         prod_q;
	logic signed [ACC_W-1:0]          acc_q;
	logic                             flag_q;
	logic [SAMPLE_WIDTH-1:0]          sample_out_q;
	logic                             clipped_q;

	logic [3*COEF_WIDTH-1:0]          ff_sel;
	logic [2*COEF_WIDTH-1:0]          fb_sel;
	logic signed [COEF_WIDTH-1:0]     mul_coef;
	logic signed [WORD_W-1:0]         mul_data;

	logic signed [ACC_W-1:0]          w_sum;
	logic signed [WR_W-1:0]           w_rnd;
	logic                             w_hi;
	logic                             w_lo;
	logic signed [WORD_W-1:0]         w_sat;
	logic signed [ACC_W-1:0]          y_sum;
	logic signed [YR_W-1:0]           y_rnd;
	logic                             y_hi;
	logic                             y_lo;
	logic signed [SAMPLE_WIDTH-1:0]   y_sat;

	assign sample_out = sample_out_q;
	assign clipped    = clipped_q;

	// coefficient registers; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SECTIONS; s++) begin
				coef_ff_q[s] <= FF_RESET;
				coef_fb_q[s] <= '0;
			end
		end else if (cfg_we) begin
			for (int s = 0; s < SECTIONS; s++) begin
				if ((2*s < REG_COUNT) && cfg_index == CFG_INDEX_W'(2*s)) begin
					coef_ff_q[s] <= cfg_data;
				end
				if ((2*s + 1 < REG_COUNT) && cfg_index == CFG_INDEX_W'(2*s + 1)) begin
					coef_fb_q[s] <= cfg_data[2*COEF_WIDTH-1:0];
				end
			end
		end
	end

	assign ff_sel = coef_ff_q[sec];
	assign fb_sel = coef_fb_q[sec];

	always_comb begin
		case (cmd.mul_sel)
			MUL_A1W1: begin
				mul_coef = fb_sel[COEF_WIDTH-1:0];
				mul_data = w1_q[sec];
			end
			MUL_A2W2: begin
				mul_coef = fb_sel[2*COEF_WIDTH-1:COEF_WIDTH];
				mul_data = w2_q[sec];
			end
			MUL_B1W1: begin
				mul_coef = ff_sel[2*COEF_WIDTH-1:COEF_WIDTH];
				mul_data = w1_q[sec];
			end
			MUL_B2W2: begin
				mul_coef = ff_sel[3*COEF_WIDTH-1:2*COEF_WIDTH];
				mul_data = w2_q[sec];
			end
			default: begin
				mul_coef = ff_sel[COEF_WIDTH-1:0];
				mul_data = w_q;
			end
		endcase
	end

	// round half up, then saturate
	assign w_sum = acc_q + W_HALF;
	assign w_rnd = w_sum[ACC_W-1:CF];
	assign w_hi  = w_rnd > WR_W'(W_MAX);
	assign w_lo  = w_rnd < WR_W'(W_MIN);
	assign w_sat = w_hi ? W_MAX : (w_lo ? W_MIN : w_rnd[WORD_W-1:0]);

	assign y_sum = acc_q + Y_HALF;
	assign y_rnd = y_sum[ACC_W-1:CF+GUARD_BITS];
	assign y_hi  = y_rnd > YR_W'(S_MAX);
	assign y_lo  = y_rnd < YR_W'(S_MIN);
	assign y_sat = y_hi ? S_MAX : (y_lo ? S_MIN : y_rnd[SAMPLE_WIDTH-1:0]);

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_coef) * PROD_W'(mul_data);
		case (cmd.acc_op)
			ACC_LOAD_X: acc_q <= ACC_W'(x_q) <<< XSHIFT;
			ACC_SUB:    acc_q <= acc_q - ACC_W'(prod_q);
			ACC_LOAD_P: acc_q <= ACC_W'(prod_q);
			ACC_ADD:    acc_q <= acc_q + ACC_W'(prod_q);
			default:    acc_q <= acc_q;
		endcase
		if (cmd.load_x) begin
			x_q <= in_sample;
		end else if (cmd.finish) begin
			x_q <= y_sat;
		end
		if (cmd.latch_w) begin
			w_q <= w_sat;
		end
		if (cmd.load_out) begin
			sample_out_q <= x_q;
			clipped_q    <= flag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else if (cmd.load_x) begin
			flag_q <= 1'b0;
		end else if (cmd.latch_w) begin
			flag_q <= flag_q | w_hi | w_lo;
		end else if (cmd.finish) begin
			flag_q <= flag_q | y_hi | y_lo;
		end
	end

	// delay line shift of the active section
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SECTIONS; s++) begin
				w1_q[s] <= '0;
				w2_q[s] <= '0;
			end
		end else if (cmd.finish) begin
			w2_q[sec] <= w1_q[sec];
			w1_q[sec] <= w_q;
		end
	end

endmodule

// ===== rtl/core/biquad_cascade_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_cascade_filter
// Cascade of direct form II biquad sections on one shared multiplier.
// ----------------------------------------------------------------------------
// a result is loaded into the output register after the last section, once that register is free
// a new input item is taken only after the previous result has been loaded
// each section takes seven steps of the single multiply-accumulate unit
// a finished result waits in the output register while the next item runs
// reset: delay words cleared, b0 = 1.0 and all other coefficients zero
// ----------------------------------------------------------------------------
module biquad_cascade_filter #(
	parameter int SECTIONS     = bqc_pkg::DEF_SECTIONS,
	parameter int SAMPLE_WIDTH = bqc_pkg::DEF_SAMPLE_WIDTH,
	parameter int COEF_WIDTH   = bqc_pkg::DEF_COEF_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [bqc_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [3*COEF_WIDTH-1:0]               cfg_data,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_tdata,   // sample_in
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     m_tdata,   // sample_out
	output logic [0:0]                            m_tuser    // clipped
);
	import bqc_pkg::*;

	localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
	localparam int SEC_W  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

	cmd_t                    cmd;
	logic [SEC_W-1:0]        sec;
	logic [SAMPLE_WIDTH-1:0] sample_out;
	logic                    clipped;

	assign cfg_ready = 1'b1;
	assign m_tdata   = DATA_W'(sample_out);
	assign m_tuser   = clipped;

	bqc_ctrl #(
		.SECTIONS (SECTIONS),
		.SEC_W    (SEC_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sec      (sec)
	);

	bqc_datapath #(
		.SECTIONS     (SECTIONS),
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COEF_WIDTH   (COEF_WIDTH),
		.SEC_W        (SEC_W)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.sec        (sec),
		.in_sample  (s_tdata[SAMPLE_WIDTH-1:0]),
		.sample_out (sample_out),
		.clipped    (clipped)
	);

endmodule

// ===== dv/tb_biquad_cascade_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_biquad_cascade_filter
// Streams samples through the three-section biquad cascade and checks every
// filtered sample and its clip flag against a bit-exact fixed-point predictor.
// Coefficient sets range from pass-through and stable filters to the
// extreme codes. Both stream sides idle at random, and one stretch holds
// the output back so that the input backs up.
// ----------------------------------------------------------------------------
module tb_biquad_cascade_filter;

	localparam int SECTIONS  = bqc_pkg::DEF_SECTIONS;
	localparam int SW        = bqc_pkg::DEF_SAMPLE_WIDTH;
	localparam int CW        = bqc_pkg::DEF_COEF_WIDTH;
	localparam int GB        = bqc_pkg::GUARD_BITS;
	localparam int COEF_FRAC = CW - 2;
	localparam int DATA_W    = ((SW + 7) / 8) * 8;
	localparam int REG_W     = 3 * CW;

	localparam longint WORD_MAX   = (longint'(1) <<< (bqc_pkg::WORD_W - 1)) - 1;
	localparam longint WORD_MIN   = -(longint'(1) <<< (bqc_pkg::WORD_W - 1));
	localparam longint SAMPLE_MAX = (longint'(1) <<< (SW - 1)) - 1;
	localparam longint SAMPLE_MIN = -(longint'(1) <<< (SW - 1));

	localparam logic [SW-1:0] PEAK_POS = {1'b0, {(SW - 1){1'b1}}};
	localparam logic [SW-1:0] PEAK_NEG = {1'b1, {(SW - 1){1'b0}}};
	localparam logic [CW-1:0] COEF_POS = {1'b0, {(CW - 1){1'b1}}};
	localparam logic [CW-1:0] COEF_NEG = {1'b1, {(CW - 1){1'b0}}};
	localparam logic [CW-1:0] COEF_ONE = CW'(1) << COEF_FRAC;
	localparam logic [REG_W-1:0] UNITY_FF = REG_W'(COEF_ONE);

	localparam int SETTLE_CYCLES  = 7 * SECTIONS + 9;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 3000;

	typedef enum logic [bqc_pkg::CFG_INDEX_W-1:0] {
		REG_S1_FF,
		REG_S1_FB,
		REG_S2_FF,
		REG_S2_FB,
		REG_S3_FF,
		REG_S3_FB,
		REG_SPARE_A,
		REG_SPARE_B
	} coef_reg_e;

	typedef enum {
		COEF_MILD,
		COEF_WILD,
		COEF_MAX,
		COEF_MIN,
		COEF_ZERO,
		COEF_UNITY
	} coef_mode_e;

	typedef struct packed {
		logic [SW-1:0] sample;
		logic          clipped;
	} filtered_t;

	logic                                clk;
	logic                                arst_n;
	logic                                cfg_valid;
	logic                                cfg_ready;
	logic [bqc_pkg::CFG_INDEX_W-1:0]     cfg_index;
	logic [REG_W-1:0]                    cfg_data;
	logic                                s_tvalid;
	logic                                s_tready;
	logic [DATA_W-1:0]                   s_tdata;
	logic                                m_tvalid;
	logic                                m_tready;
	logic [DATA_W-1:0]                   m_tdata;
	logic [0:0]                          m_tuser;

	// predictor copy of the coefficients and delay words
	longint ff_coef [SECTIONS][3];
	longint fb_coef [SECTIONS][2];
	int     delay_word [2*SECTIONS];

	logic [SW-1:0] sample_queue [$];
	filtered_t     expected_out [$];

	logic in_fire;
	bit   allow_gaps;
	bit   hold_request;
	int   send_gap;
	int   ready_wait;
	int   quiet_cycles;
	int   out_count;
	int   error_count;

	biquad_cascade_filter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint round_half_up(input longint v, input int n);
		return (v + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	function automatic longint clamp(input longint v, input longint lo, input longint hi,
			inout logic hit);
		if (v > hi) begin
			hit = 1'b1;
			return hi;
		end
		if (v < lo) begin
			hit = 1'b1;
			return lo;
		end
		return v;
	endfunction

	// one sample through all sections, updating the delay words
	function automatic filtered_t run_cascade(input logic signed [SW-1:0] x_in);
		filtered_t res;
		longint x, w1, w2, acc, w, y;
		logic hit;
		hit = 1'b0;
		x = longint'(x_in);
		for (int s = 0; s < SECTIONS; s++) begin
			w1 = longint'(delay_word[2*s]);
			w2 = longint'(delay_word[2*s+1]);
			acc = (x <<< (GB + COEF_FRAC)) - fb_coef[s][0] * w1 - fb_coef[s][1] * w2;
			w = clamp(round_half_up(acc, COEF_FRAC), WORD_MIN, WORD_MAX, hit);
			acc = ff_coef[s][0] * w + ff_coef[s][1] * w1 + ff_coef[s][2] * w2;
			y = clamp(round_half_up(acc, COEF_FRAC + GB), SAMPLE_MIN, SAMPLE_MAX, hit);
			delay_word[2*s+1] = int'(w1);
			delay_word[2*s] = int'(w);
			x = y;
		end
		res.sample = x[SW-1:0];
		res.clipped = hit;
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		if (!allow_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [CW-1:0] pick_coef(input coef_mode_e mode, input bit forward,
			input int tap);
		case (mode)
			COEF_MILD: begin
				// feedforward within +-1.0, feedback small enough to stay stable
				if (forward)
					return CW'($urandom_range(0, 2 * 65536) - 65536);
				return CW'($urandom_range(0, 65536) - 32768);
			end
			COEF_WILD:  return CW'($urandom);
			COEF_MAX:   return COEF_POS;
			COEF_MIN:   return COEF_NEG;
			COEF_UNITY: return (forward && tap == 0) ? COEF_ONE : '0;
			default:    return '0;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("item %0d: %s got %0d, expected %0d", out_count, what, got, want);
		error_count++;
	endtask

	task automatic write_reg(input coef_reg_e idx, input logic [REG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic program_filter(input logic [REG_W-1:0] ff1, input logic [REG_W-1:0] fb1,
			input logic [REG_W-1:0] ff2, input logic [REG_W-1:0] fb2,
			input logic [REG_W-1:0] ff3, input logic [REG_W-1:0] fb3);
		write_reg(REG_S1_FF, ff1);
		write_reg(REG_S1_FB, fb1);
		write_reg(REG_S2_FF, ff2);
		write_reg(REG_S2_FB, fb2);
		write_reg(REG_S3_FF, ff3);
		write_reg(REG_S3_FB, fb3);
	endtask

	task automatic wait_idle();
		while (sample_queue.size() != 0 || s_tvalid || expected_out.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input int count, input coef_mode_e mode, input bit gaps,
			input bit squeeze);
		logic [REG_W-1:0] ff [3];
		logic [REG_W-1:0] fb [3];
		logic [SW-1:0] smp;
		int r;
		allow_gaps = gaps;
		for (int s = 0; s < 3; s++) begin
			ff[s] = {pick_coef(mode, 1'b1, 2), pick_coef(mode, 1'b1, 1), pick_coef(mode, 1'b1, 0)};
			// bits above the feedback pair are don't-care
			fb[s] = {CW'($urandom), pick_coef(mode, 1'b0, 1), pick_coef(mode, 1'b0, 0)};
		end
		program_filter(ff[0], fb[0], ff[1], fb[1], ff[2], fb[2]);
		write_reg(REG_SPARE_A, REG_W'({$urandom, $urandom}));
		write_reg(REG_SPARE_B, REG_W'({$urandom, $urandom}));
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 50)
				smp = SW'($urandom);
			else if (r < 75)
				smp = SW'($urandom_range(0, 2047) - 1024);
			else if (r < 88)
				smp = r[0] ? PEAK_POS : PEAK_NEG;
			else
				smp = '0;
			sample_queue.push_back(smp);
		end
		if (squeeze)
			hold_request = 1'b1;
		wait_idle();
	endtask

	// sender
	always @(negedge clk) begin
		if (!s_tvalid || in_fire) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (sample_queue.size() != 0) begin
				s_tdata  <= DATA_W'(sample_queue.pop_front());
				s_tvalid <= 1'b1;
				send_gap = pick_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver, with the long hold-off counted here
	always @(negedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			ready_wait = HOLD_CYCLES;
		end
		if (ready_wait > 0) begin
			ready_wait--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			ready_wait = pick_gap();
		end
	end

	// checks outputs, predicts accepted inputs, tracks register writes
	always @(posedge clk) begin
		filtered_t want;
		int sec;
		in_fire <= s_tvalid && s_tready;
		if (m_tvalid && m_tready) begin
			if (expected_out.size() == 0) begin
				report_mismatch("unexpected item", longint'($signed(m_tdata[SW-1:0])), 0);
			end else begin
				want = expected_out.pop_front();
				if (m_tdata[SW-1:0] !== want.sample)
					report_mismatch("sample_out", longint'($signed(m_tdata[SW-1:0])),
						longint'($signed(want.sample)));
				if (m_tuser[0] !== want.clipped)
					report_mismatch("clipped", longint'(m_tuser[0]), longint'(want.clipped));
			end
			out_count++;
		end
		if (s_tvalid && s_tready)
			expected_out.push_back(run_cascade($signed(s_tdata[SW-1:0])));
		if (cfg_valid && cfg_ready && cfg_index < bqc_pkg::REG_COUNT) begin
			sec = int'(cfg_index >> 1);
			for (int k = 0; k < 3; k++) begin
				if (!cfg_index[0])
					ff_coef[sec][k] = longint'($signed(cfg_data[k*CW +: CW]));
				else if (k < 2)
					fb_coef[sec][k] = longint'($signed(cfg_data[k*CW +: CW]));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		logic [SW-1:0] opening [8];
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		in_fire = 1'b0;
		allow_gaps = 1'b1;
		hold_request = 1'b0;
		send_gap = 0;
		ready_wait = 0;
		quiet_cycles = 0;
		out_count = 0;
		error_count = 0;
		for (int s = 0; s < SECTIONS; s++) begin
			ff_coef[s] = '{longint'(COEF_ONE), 0, 0};
			fb_coef[s] = '{0, 0};
			delay_word[2*s] = 0;
			delay_word[2*s+1] = 0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset coefficients pass samples straight through
		opening = '{PEAK_POS, PEAK_NEG, SW'(0), SW'(1), SW'(-1), 16'h5555, 16'haaaa,
			SW'(12345)};
		foreach (opening[i])
			sample_queue.push_back(opening[i]);
		wait_idle();

		// b0 just under 2.0 on the first section: output saturates
		program_filter({{2*CW{1'b0}}, COEF_POS}, '0, UNITY_FF, '0, UNITY_FF, '0);
		sample_queue.push_back(PEAK_POS);
		sample_queue.push_back(PEAK_NEG);
		sample_queue.push_back(16'h4000);
		wait_idle();

		// a1 = a2 = -2.0 makes the delay words run away until they saturate;
		// spare indexes and bits above the feedback pair must be ignored
		program_filter(UNITY_FF, {CW'($urandom), COEF_NEG, COEF_NEG},
			UNITY_FF, '0, UNITY_FF, '0);
		write_reg(REG_SPARE_A, REG_W'({$urandom, $urandom}));
		write_reg(REG_SPARE_B, REG_W'({$urandom, $urandom}));
		repeat (6) sample_queue.push_back(PEAK_POS);
		repeat (4) sample_queue.push_back(PEAK_NEG);
		wait_idle();

		run_phase(300, COEF_MILD, 1'b1, 1'b0);
		run_phase(250, COEF_MILD, 1'b0, 1'b0);
		run_phase(200, COEF_WILD, 1'b1, 1'b0);
		run_phase(100, COEF_MAX, 1'b1, 1'b0);
		run_phase(100, COEF_MIN, 1'b1, 1'b0);
		run_phase(100, COEF_ZERO, 1'b1, 1'b0);
		run_phase(300, COEF_MILD, 1'b1, 1'b1);
		run_phase(100, COEF_UNITY, 1'b1, 1'b0);
		run_phase(300, COEF_MILD, 1'b1, 1'b0);

		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/bqc_pkg.sv
rtl/core/bqc_ctrl.sv
rtl/core/bqc_datapath.sv
rtl/core/biquad_cascade_filter.sv
dv/tb_biquad_cascade_filter.sv
